### rtl/qrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// shared widths, status codes and pipeline tag types of the quadratic solver
// ----------------------------------------------------------------------------
package qrs_pkg;

  // square root: one result bit per stage
  localparam int SQ_STEPS = 25;
  localparam int RAD_W    = 2 * SQ_STEPS;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = SQ_STEPS + 3;

  // divider: one quotient bit per stage
  localparam int DIV_STEPS = 34;
  localparam int DVS_W     = 17;
  localparam int DREM_W    = DVS_W + 1;

  // root status codes
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_ONE   = 2'd1;
  localparam logic [1:0] ST_TWO   = 2'd2;
  localparam logic [1:0] ST_AZERO = 2'd3;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [24:0]  nb;
    logic signed [15:0]  a;
  } qrs_sq_tag_t;

  typedef struct packed {
    logic [1:0] status;
    logic       neg1;
    logic       neg2;
  } qrs_div_tag_t;

endpackage
`default_nettype wire

### rtl/quadratic_root_solver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// real roots of a*x^2 + b*x + c from signed q8.8 coefficients
// ----------------------------------------------------------------------------
// One coefficient set is taken per clock (busy stays low) and its result
// is on the result ports with out_strobe, in order, after it has passed the
// input, product and discriminant registers, the 25-stage square root, the
// numerator register, the 34-stage divider, the saturation register and the
// output register;
// the receiver cannot stall, so every result transfer happens on its strobe
// cycle. Status: 0 no real root, 1 one root, 2 two roots, 3 a is zero.
// Roots are signed q16.16, truncated toward zero and saturated.
module quadratic_root_solver_unit import qrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_coef_a,
  input  wire logic signed [15:0] in_coef_b,
  input  wire logic signed [15:0] in_coef_c,
  output logic                    out_strobe,
  output logic [1:0]              out_root_status,
  output logic signed [31:0]      out_solution_one,
  output logic signed [31:0]      out_solution_two
);

  // saturate a sign and magnitude quotient to q16.16
  function automatic logic [31:0] sat32(input logic neg, input logic [DIV_STEPS-1:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag > 34'h0_8000_0000) res = 32'h8000_0000;
      else                       res = 32'd0 - mag[31:0];
    end else begin
      if (mag > 34'h0_7fff_ffff) res = 32'h7fff_ffff;
      else                       res = mag[31:0];
    end
    return res;
  endfunction

  // the pipeline never stalls
  assign busy = 1'b0;

  // input register
  logic               v0_r;
  logic signed [15:0] a0_r, b0_r, c0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    a0_r <= in_coef_a;
    b0_r <= in_coef_b;
    c0_r <= in_coef_c;
  end

  // products b*b and a*c
  logic               v1_r;
  logic signed [31:0] bb1_r, ac1_r;
  logic signed [15:0] a1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    bb1_r <= b0_r * b0_r;
    ac1_r <= a0_r * c0_r;
    a1_r  <= a0_r;
    b1_r  <= b0_r;
  end

  // discriminant, status class and sqrt radicand
  logic signed [34:0] disc;
  logic [1:0]         st2;
  logic               v2_r;
  logic [RAD_W-1:0]   rad2_r;
  qrs_sq_tag_t        tag2_r;

  always_comb begin
    disc = {{3{bb1_r[31]}}, bb1_r} - {ac1_r[31], ac1_r, 2'b00};
    if (a1_r == 16'sd0)      st2 = ST_AZERO;
    else if (disc[34])       st2 = ST_NONE;
    else if (disc == 35'sd0) st2 = ST_ONE;
    else                     st2 = ST_TWO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    // radicand is d scaled by 2^16; a negative d feeds zero
    rad2_r        <= disc[34] ? '0 : {1'b0, disc[32:0], 16'h0000};
    tag2_r.status <= st2;
    tag2_r.nb     <= 25'sd0 - {b1_r[15], b1_r, 8'h00};
    tag2_r.a      <= a1_r;
  end

  // square root pipeline
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  qrs_sq_tag_t       sq_tag;

  qrs_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_rad    (rad2_r),
    .in_tag    (tag2_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // numerators -b*256 +/- s, split into sign and magnitude
  logic signed [26:0]   n1, n2, nbx, sx, m1, m2;
  logic [15:0]          amag;
  logic                 v3_r;
  logic [DIV_STEPS-1:0] num1_r, num2_r;
  logic [DVS_W-1:0]     dvs3_r;
  qrs_div_tag_t         tag3_r;

  always_comb begin
    nbx  = {{2{sq_tag.nb[24]}}, sq_tag.nb};
    sx   = {2'b00, sq_root};
    n1   = nbx + sx;
    n2   = nbx - sx;
    m1   = n1[26] ? 27'sd0 - n1 : n1;
    m2   = n2[26] ? 27'sd0 - n2 : n2;
    amag = sq_tag.a[15] ? 16'd0 - sq_tag.a : sq_tag.a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= sq_v;
    end
    num1_r        <= {m1[25:0], 8'h00};
    num2_r        <= {m2[25:0], 8'h00};
    dvs3_r        <= {amag, 1'b0};
    tag3_r.status <= sq_tag.status;
    tag3_r.neg1   <= n1[26] ^ sq_tag.a[15];
    tag3_r.neg2   <= n2[26] ^ sq_tag.a[15];
  end

  // divide both numerators by 2a
  logic                 dv_v;
  logic [DIV_STEPS-1:0] quo1, quo2;
  qrs_div_tag_t         dv_tag;

  qrs_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_num1   (num1_r),
    .in_num2   (num2_r),
    .in_dvs    (dvs3_r),
    .in_tag    (tag3_r),
    .out_valid (dv_v),
    .out_quo1  (quo1),
    .out_quo2  (quo2),
    .out_tag   (dv_tag)
  );

  // saturation
  logic               v4_r;
  logic signed [31:0] r1_r, r2_r;
  logic [1:0]         st4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= dv_v;
    end
    r1_r  <= sat32(dv_tag.neg1, quo1);
    r2_r  <= sat32(dv_tag.neg2, quo2);
    st4_r <= dv_tag.status;
  end

  // ordering and masking into the output register
  logic               swap;
  logic signed [31:0] sol1_nxt, sol2_nxt;

  always_comb begin
    swap = (r1_r <= 32'sd0) && (r2_r > 32'sd0);
    case (st4_r)
      ST_TWO: begin
        sol1_nxt = swap ? r2_r : r1_r;
        sol2_nxt = swap ? r1_r : r2_r;
      end
      ST_ONE: begin
        sol1_nxt = r1_r;
        sol2_nxt = 32'sd0;
      end
      default: begin
        sol1_nxt = 32'sd0;
        sol2_nxt = 32'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= v4_r;
    end
    out_root_status  <= st4_r;
    out_solution_one <= sol1_nxt;
    out_solution_two <= sol2_nxt;
  end

`ifndef NO_ASSERTIONS
  // no root reported unless the status says so
  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_root_status == ST_NONE || out_root_status == ST_AZERO)
      |-> out_solution_one == 32'sd0 && out_solution_two == 32'sd0)
    else $error("solutions not zero without a real root");

  a_one_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_root_status == ST_ONE |-> out_solution_two == 32'sd0)
    else $error("second solution set for a single root");

  // a positive root, when there is one, is reported first
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_root_status == ST_TWO
      |-> out_solution_one > 32'sd0 || out_solution_two <= 32'sd0)
    else $error("two roots in the wrong order");
`endif

endmodule
`default_nettype wire

### rtl/qrs_sqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe
// pipelined truncating integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe import qrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [RAD_W-1:0]  in_rad,
  input  wire qrs_sq_tag_t       in_tag,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root,
  output qrs_sq_tag_t            out_tag
);

  logic              vld_r  [0:SQ_STEPS];
  logic [RAD_W-1:0]  rad_r  [0:SQ_STEPS];
  logic [REM_W-1:0]  rem_r  [0:SQ_STEPS];
  logic [ROOT_W-1:0] root_r [0:SQ_STEPS];
  qrs_sq_tag_t       tag_r  [0:SQ_STEPS];

  // stage 0 is the input itself
  assign vld_r[0]  = in_valid;
  assign rad_r[0]  = in_rad;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign tag_r[0]  = in_tag;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [REM_W-1:0]  shf;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    always_comb begin
      shf   = {rem_r[k][REM_W-3:0], rad_r[k][RAD_W-1 -: 2]};
      trial = {1'b0, root_r[k], 2'b01};
      if (shf >= trial) begin
        rem_nxt  = shf - trial;
        root_nxt = {root_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shf;
        root_nxt = {root_r[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      rad_r[k+1]  <= {rad_r[k][RAD_W-3:0], 2'b00};
      rem_r[k+1]  <= rem_nxt;
      root_r[k+1] <= root_nxt;
      tag_r[k+1]  <= tag_r[k];
    end
  end

  assign out_valid = vld_r[SQ_STEPS];
  assign out_root  = root_r[SQ_STEPS];
  assign out_tag   = tag_r[SQ_STEPS];

endmodule
`default_nettype wire

### rtl/qrs_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div_pipe
// two-lane pipelined restoring divider sharing one divisor
// ----------------------------------------------------------------------------
module qrs_div_pipe import qrs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [DIV_STEPS-1:0] in_num1,
  input  wire logic [DIV_STEPS-1:0] in_num2,
  input  wire logic [DVS_W-1:0]     in_dvs,
  input  wire qrs_div_tag_t         in_tag,
  output logic                      out_valid,
  output logic [DIV_STEPS-1:0]      out_quo1,
  output logic [DIV_STEPS-1:0]      out_quo2,
  output qrs_div_tag_t              out_tag
);

  logic                 vld_r  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] num1_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] num2_r [0:DIV_STEPS];
  logic [DREM_W-1:0]    rem1_r [0:DIV_STEPS];
  logic [DREM_W-1:0]    rem2_r [0:DIV_STEPS];
  logic [DVS_W-1:0]     dvs_r  [0:DIV_STEPS];
  qrs_div_tag_t         tag_r  [0:DIV_STEPS];

  assign vld_r[0]  = in_valid;
  assign num1_r[0] = in_num1;
  assign num2_r[0] = in_num2;
  assign rem1_r[0] = '0;
  assign rem2_r[0] = '0;
  assign dvs_r[0]  = in_dvs;
  assign tag_r[0]  = in_tag;

  // quotient bits shift into the bottom of the dividend register
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DREM_W-1:0] shf1, shf2, rem1_nxt, rem2_nxt, dvx;
    logic              q1, q2;

    always_comb begin
      dvx  = {1'b0, dvs_r[k]};
      shf1 = {rem1_r[k][DREM_W-2:0], num1_r[k][DIV_STEPS-1]};
      shf2 = {rem2_r[k][DREM_W-2:0], num2_r[k][DIV_STEPS-1]};
      q1   = (shf1 >= dvx);
      q2   = (shf2 >= dvx);
      rem1_nxt = q1 ? shf1 - dvx : shf1;
      rem2_nxt = q2 ? shf2 - dvx : shf2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      num1_r[k+1] <= {num1_r[k][DIV_STEPS-2:0], q1};
      num2_r[k+1] <= {num2_r[k][DIV_STEPS-2:0], q2};
      rem1_r[k+1] <= rem1_nxt;
      rem2_r[k+1] <= rem2_nxt;
      dvs_r[k+1]  <= dvs_r[k];
      tag_r[k+1]  <= tag_r[k];
    end
  end

  assign out_valid = vld_r[DIV_STEPS];
  assign out_quo1  = num1_r[DIV_STEPS];
  assign out_quo2  = num2_r[DIV_STEPS];
  assign out_tag   = tag_r[DIV_STEPS];

endmodule
`default_nettype wire

### bench/quadratic_root_solver_unit_test.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit_test
// self-checking bench for the quadratic root solver
// ----------------------------------------------------------------------------
// Coefficient sets are queued by an initial block and driven on the falling
// edge. The bench computes the expected status and roots at each accepted
// transfer, then compares them in order with the strobed results.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } coef_set_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] one;
    logic signed [31:0] two;
  } root_set_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [15:0] in_coef_a, in_coef_b, in_coef_c;
  logic out_strobe;
  logic [1:0] out_root_status;
  logic signed [31:0] out_solution_one, out_solution_two;

  coef_set_t coef_queue[$];
  root_set_t expected_roots[$];
  int  mismatch_count;
  int  cycle_count;
  int  gap_left;
  bit  gaps_enabled;
  localparam int CYCLE_LIMIT = 200000;

  quadratic_root_solver_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_strobe(out_strobe), .out_root_status(out_root_status),
    .out_solution_one(out_solution_one), .out_solution_two(out_solution_two)
  );

  // 20 ns period
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // integer square root, truncated
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // q16.16 quotient, truncated toward zero and saturated
  function automatic longint divide_root(longint num, longint a);
    longint q;
    q = (num * 256) / (2 * a);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic root_set_t solve_roots(coef_set_t cs);
    root_set_t r;
    longint a, b, c, disc, sq, nb, r1, r2;
    a = cs.a;
    b = cs.b;
    c = cs.c;
    r.status = ST_AZERO;
    r.one    = '0;
    r.two    = '0;
    if (a == 0) return r;
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      r.status = ST_NONE;
      return r;
    end
    nb = -b * 256;
    if (disc == 0) begin
      r.status = ST_ONE;
      r.one    = 32'(divide_root(nb, a));
      return r;
    end
    sq = longint'(isqrt(longint'(disc) << 16));
    r1 = divide_root(nb + sq, a);
    r2 = divide_root(nb - sq, a);
    r.status = ST_TWO;
    // positive root goes first when only the second one is positive
    if (r1 <= 0 && r2 > 0) begin
      r.one = 32'(r2);
      r.two = 32'(r1);
    end else begin
      r.one = 32'(r1);
      r.two = 32'(r2);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  task automatic queue_set(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    coef_set_t cs;
    cs.a = a;
    cs.b = b;
    cs.c = c;
    coef_queue.push_back(cs);
  endtask

  // driver: a transfer completes on a rising edge with start high, busy low
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_roots.push_back(solve_roots('{in_coef_a, in_coef_b, in_coef_c}));
      void'(coef_queue.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (gaps_enabled && $urandom_range(0, 15) == 0) begin
      gap_left = $urandom_range(1, 18) - 1;
      start <= 1'b0;
    end else if (coef_queue.size() > 0) begin
      start     <= 1'b1;
      in_coef_a <= coef_queue[0].a;
      in_coef_b <= coef_queue[0].b;
      in_coef_c <= coef_queue[0].c;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: each strobe is one result transfer
  always @(posedge clk) begin
    root_set_t want;
    cycle_count++;
    if (rst_n && out_strobe) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected result", out_root_status, -1);
      end else begin
        want = expected_roots.pop_front();
        if (out_root_status !== want.status)
          report_mismatch("root_status", out_root_status, want.status);
        if (out_solution_one !== want.one)
          report_mismatch("solution_one", out_solution_one, want.one);
        if (out_solution_two !== want.two)
          report_mismatch("solution_two", out_solution_two, want.two);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] edge_vals[6];
    int k;
    int sa, sb, sc;
    mismatch_count = 0;
    cycle_count    = 0;
    gap_left       = 0;
    gaps_enabled   = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_coef_a = '0;
    in_coef_b = '0;
    in_coef_c = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: a zero, negative/zero/positive discriminant, extremes
    queue_set(16'h0000, 16'h1234, 16'h0100);
    queue_set(16'h0100, 16'h0000, 16'h0100);   // x^2+1, no real root
    queue_set(16'h0100, 16'hFE00, 16'h0100);   // (x-1)^2, one root
    queue_set(16'h0100, 16'h0000, 16'hFF00);   // x^2-1, two roots
    queue_set(16'hFF00, 16'h0000, 16'h0100);   // negative a
    queue_set(16'h0100, 16'h0300, 16'h0200);   // both roots negative
    queue_set(16'h0100, 16'hFD00, 16'h0200);   // both positive
    queue_set(16'h0001, 16'h7FFF, 16'h0000);   // saturating root
    queue_set(16'h0001, 16'h8000, 16'h8000);
    queue_set(16'hFFFF, 16'h7FFF, 16'h7FFF);
    edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0100};
    for (k = 0; k < 12; k++)
      queue_set(edge_vals[k % 6], edge_vals[(k + 1) % 6], edge_vals[(k + 3) % 6]);

    // random: mix full range, small magnitudes and exact perfect squares
    gaps_enabled = 1'b1;
    for (k = 0; k < 1350; k++) begin
      if (k == 1150) begin
        wait (coef_queue.size() == 0);
        gaps_enabled = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: queue_set(16'($urandom), 16'($urandom), 16'($urandom));
        1: queue_set(16'($urandom_range(0, 1023) - 512),
                     16'($urandom_range(0, 4095) - 2048),
                     16'($urandom_range(0, 1023) - 512));
        2: begin
          // b = 2*sa*sb, a = sa*sa... built so the discriminant is zero
          sa = $urandom_range(1, 15);
          sb = $urandom_range(0, 15) - 8;
          queue_set(16'(sa * sa), 16'(2 * sa * sb), 16'(sb * sb));
        end
        default: begin
          sc = $urandom_range(0, 200) - 100;
          queue_set($urandom_range(0, 1) ? 16'(sc) : 16'(-sc - 1),
                    16'($urandom), $urandom_range(0, 1) ? 16'h0000 : 16'($urandom));
        end
      endcase
      if (coef_queue.size() > 64) wait (coef_queue.size() < 16);
    end
    wait (coef_queue.size() == 0);
    wait (expected_roots.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && expected_roots.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
